### hdl/bars_pkg.sv
// ----------------------------------------------------------------------------
// bars_pkg
// Shared types and constants for the byte alignment range search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bars_pkg;

    localparam int DEPTH_DEFAULT = 4096;

    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int WIN_W    = 13;
    localparam int POS_W    = 12;
    localparam int LEN_W    = 13;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_WR_SRC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_TGT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data_byte;
        logic [WIN_W-1:0]  src_begin;
        logic [WIN_W-1:0]  src_limit;
        logic [WIN_W-1:0]  tgt_begin;
        logic [WIN_W-1:0]  tgt_limit;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_src_pos;
        logic [POS_W-1:0] match_tgt_pos;
        logic [LEN_W-1:0] match_length;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAIR,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### hdl/byte_alignment_range_search.sv
// ----------------------------------------------------------------------------
// byte_alignment_range_search
// Loads source and target byte buffers and searches two windows for the
// first start pair with an alignment run longer than one byte.
// ----------------------------------------------------------------------------
//  channel   handshake              payload          role
//  req       req_valid/req_ready    bars_pkg::req_t  byte writes and searches
//  rsp       rsp_valid/rsp_ready    bars_pkg::rsp_t  one result per search
//
//  A byte write yields no result.
//  A search latches its window, then per start pair runs a setup state plus
//  one byte compared per cycle (one read port per buffer), then loads the
//  result register once it is free. An empty window goes straight to the result.
//  No clearing pass after reset; buffer contents are undefined until written.
//  A new request is taken while a result waits on a stalled rsp channel.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_alignment_range_search #(
    parameter int DEPTH = bars_pkg::DEPTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire bars_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output bars_pkg::rsp_t       rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ($clog2(DEPTH + 1) > bars_pkg::ADDR_W) ?
                        $clog2(DEPTH + 1) : bars_pkg::ADDR_W + 1;

    logic                        wr_accept;
    logic                        addr_ok;
    logic                        src_we, tgt_we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               src_raddr, tgt_raddr;
    logic [bars_pkg::BYTE_W-1:0] src_rdata, tgt_rdata;

    // writes at or above DEPTH are dropped
    assign wr_accept = req_valid && req_ready;
    assign addr_ok   = (CW'(req.addr) < CW'(DEPTH));
    assign src_we    = wr_accept && addr_ok && (req.func == bars_pkg::FUNC_WR_SRC);
    assign tgt_we    = wr_accept && addr_ok && (req.func == bars_pkg::FUNC_WR_TGT);
    assign waddr     = AW'(req.addr);

    // writes only happen in idle and reads only during a search: no overlap
    bars_ram #(
        .WIDTH (bars_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (waddr),
        .wdata (req.data_byte),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    bars_ram #(
        .WIDTH (bars_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (waddr),
        .wdata (req.data_byte),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    bars_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .src_raddr (src_raddr),
        .tgt_raddr (tgt_raddr),
        .src_rdata (src_rdata),
        .tgt_rdata (tgt_rdata)
    );

endmodule

`default_nettype wire

### hdl/bars_ram.sv
// ----------------------------------------------------------------------------
// bars_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/bars_ctrl.sv
// ----------------------------------------------------------------------------
// bars_ctrl
// Search sequencer: walks source/target start pairs, streams byte compares
// out of the two memories and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bars_ctrl #(
    parameter int DEPTH = bars_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire bars_pkg::req_t                  req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output bars_pkg::rsp_t                       rsp,
    output logic [$clog2(DEPTH)-1:0]             src_raddr,
    output logic [$clog2(DEPTH)-1:0]             tgt_raddr,
    input  wire logic [bars_pkg::BYTE_W-1:0]     src_rdata,
    input  wire logic [bars_pkg::BYTE_W-1:0]     tgt_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ($clog2(DEPTH + 1) > bars_pkg::WIN_W) ?
                        $clog2(DEPTH + 1) : bars_pkg::WIN_W;

    bars_pkg::state_t state_reg, state_next;

    logic [CW-1:0] s_reg, s_next;
    logic [CW-1:0] t_reg, t_next;
    logic [CW-1:0] sl_reg, sl_next;
    logic [CW-1:0] tl_reg, tl_next;
    logic [CW-1:0] tb_reg, tb_next;
    logic [CW-1:0] span_reg, span_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] hits_reg, hits_next;
    bars_pkg::rsp_t res_reg, res_next;
    bars_pkg::rsp_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic          is_search;
    logic [CW-1:0] sb_ext, tb_ext, sl_ext, tl_ext;
    logic [CW-1:0] sl_clamp, tl_clamp;
    logic          window_empty;
    logic [CW-1:0] span_s, span_t, span_min;
    logic [CW-1:0] compared;
    logic          byte_eq;
    logic [CW-1:0] run_new;
    logic [CW-1:0] hits_new;
    logic          stop_early;
    logic          pair_end;
    logic          pair_hit;
    logic [CW-1:0] t_inc, s_inc;
    logic          t_more, s_more;
    logic          search_done;
    logic          emit_take;
    logic [CW-1:0] src_idx, tgt_idx;

    assign req_ready = (state_reg == bars_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign is_search = (req.func == bars_pkg::FUNC_SEARCH);

    assign sb_ext   = CW'(req.src_begin);
    assign tb_ext   = CW'(req.tgt_begin);
    assign sl_ext   = CW'(req.src_limit);
    assign tl_ext   = CW'(req.tgt_limit);
    assign sl_clamp = (sl_ext > CW'(DEPTH)) ? CW'(DEPTH) : sl_ext;
    assign tl_clamp = (tl_ext > CW'(DEPTH)) ? CW'(DEPTH) : tl_ext;
    assign window_empty = (sb_ext >= sl_clamp) || (tb_ext >= tl_clamp);

    assign span_s   = sl_reg - s_reg;
    assign span_t   = tl_reg - t_reg;
    assign span_min = (span_s < span_t) ? span_s : span_t;

    // read data in ST_SCAN belongs to offset i_reg
    assign compared   = i_reg + CW'(1);
    assign byte_eq    = (src_rdata == tgt_rdata);
    assign run_new    = byte_eq ? compared : run_reg;
    assign hits_new   = hits_reg + CW'(byte_eq);
    assign stop_early = !byte_eq && ({hits_reg, 1'b0} < {1'b0, compared});
    assign pair_end   = stop_early || (compared == span_reg);
    assign pair_hit   = pair_end && (run_new > CW'(1));

    assign t_inc  = t_reg + CW'(1);
    assign s_inc  = s_reg + CW'(1);
    assign t_more = (t_inc < tl_reg);
    assign s_more = (s_inc < sl_reg);
    assign search_done = pair_hit || (pair_end && !t_more && !s_more);

    assign emit_take = !out_valid_reg || rsp_ready;

    // next offset is fetched speculatively; dropped if the pair ends
    assign src_idx = s_reg + compared;
    assign tgt_idx = t_reg + compared;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bars_pkg::ST_IDLE:
            begin
                if (accept && is_search)
                begin
                    state_next = window_empty ? bars_pkg::ST_EMIT : bars_pkg::ST_PAIR;
                end
            end
            bars_pkg::ST_PAIR:
            begin
                state_next = bars_pkg::ST_SCAN;
            end
            bars_pkg::ST_SCAN:
            begin
                if (pair_end)
                begin
                    state_next = search_done ? bars_pkg::ST_EMIT : bars_pkg::ST_PAIR;
                end
            end
            bars_pkg::ST_EMIT:
            begin
                if (emit_take)
                begin
                    state_next = bars_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bars_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_next         = s_reg;
        t_next         = t_reg;
        sl_next        = sl_reg;
        tl_next        = tl_reg;
        tb_next        = tb_reg;
        span_next      = span_reg;
        i_next         = i_reg;
        run_next       = run_reg;
        hits_next      = hits_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        src_raddr      = s_reg[AW-1:0];
        tgt_raddr      = t_reg[AW-1:0];
        case (state_reg)
            bars_pkg::ST_IDLE:
            begin
                if (accept && is_search)
                begin
                    s_next   = sb_ext;
                    t_next   = tb_ext;
                    tb_next  = tb_ext;
                    sl_next  = sl_clamp;
                    tl_next  = tl_clamp;
                    res_next = '0;
                end
            end
            bars_pkg::ST_PAIR:
            begin
                span_next = span_min;
                i_next    = '0;
                run_next  = '0;
                hits_next = '0;
            end
            bars_pkg::ST_SCAN:
            begin
                src_raddr = src_idx[AW-1:0];
                tgt_raddr = tgt_idx[AW-1:0];
                i_next    = compared;
                run_next  = run_new;
                hits_next = hits_new;
                if (pair_end)
                begin
                    if (pair_hit)
                    begin
                        res_next.found         = 1'b1;
                        res_next.match_src_pos = s_reg[bars_pkg::POS_W-1:0];
                        res_next.match_tgt_pos = t_reg[bars_pkg::POS_W-1:0];
                        res_next.match_length  = run_new[bars_pkg::LEN_W-1:0];
                    end
                    else if (t_more)
                    begin
                        t_next = t_inc;
                    end
                    else if (s_more)
                    begin
                        s_next = s_inc;
                        t_next = tb_reg;
                    end
                end
            end
            bars_pkg::ST_EMIT:
            begin
                if (emit_take)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !rsp_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bars_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        t_reg    <= t_next;
        sl_reg   <= sl_next;
        tl_reg   <= tl_next;
        tb_reg   <= tb_next;
        span_reg <= span_next;
        i_reg    <= i_next;
        run_reg  <= run_next;
        hits_reg <= hits_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef NO_ASSERTIONS
    a_scan_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bars_pkg::ST_SCAN) |-> (i_reg < span_reg))
        else $error("compare offset ran past pair span");

    a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bars_pkg::ST_SCAN) |-> (hits_reg <= i_reg))
        else $error("hit count exceeds bytes compared");

    a_pair_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bars_pkg::ST_PAIR) || (state_reg == bars_pkg::ST_SCAN)) |->
        ((s_reg < sl_reg) && (t_reg < tl_reg) && (tl_reg <= CW'(DEPTH))
         && (sl_reg <= CW'(DEPTH))))
        else $error("pair start outside clamped window");

    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.found) |-> (out_reg.match_length > 13'd1))
        else $error("reported run too short");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |->
        ((out_reg.match_src_pos == '0) && (out_reg.match_tgt_pos == '0)
         && (out_reg.match_length == '0)))
        else $error("not-found result carries nonzero fields");
`endif

endmodule

`default_nettype wire
